// File: hw/rtl/mvt_pkg.sv
// shared types and constants for the matrix vector transform block
`default_nettype none
package mvt_pkg;

	localparam int DATA_W        = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int DIM           = 4;

	typedef logic [1:0] func_t;

	localparam func_t FUNC_LOAD  = 2'd0;
	localparam func_t FUNC_VEC   = 2'd1;
	localparam func_t FUNC_POINT = 2'd2;

	// matrix element write, broadcast to all lanes
	typedef struct packed {
		logic              en;
		logic [1:0]        row;
		logic [1:0]        col;
		logic [DATA_W-1:0] data;
	} mat_wr_t;

	// one row result as a lane hands it to the merge stage
	typedef struct packed {
		logic [DATA_W-1:0] val;
		logic              ovf;
	} lane_res_t;

endpackage
`default_nettype wire

// File: hw/rtl/mvt_if.sv
// request and response channel interfaces
`default_nettype none
interface mvt_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         func;
	logic [1:0]         row;
	logic [1:0]         col;
	logic signed [31:0] in_x;
	logic signed [31:0] in_y;
	logic signed [31:0] in_z;
	logic signed [31:0] in_w;

	modport source (output valid, func, row, col, in_x, in_y, in_z, in_w, input ready);
	modport sink (input valid, func, row, col, in_x, in_y, in_z, in_w, output ready);
endinterface

interface mvt_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;
	logic signed [31:0] out_w;
	logic               overflow;

	modport source (output valid, out_x, out_y, out_z, out_w, overflow, input ready);
	modport sink (input valid, out_x, out_y, out_z, out_w, overflow, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/mvt_lane.sv
// one matrix row: element storage, four multipliers, adder and saturation
`default_nettype none
module mvt_lane #(
	parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEF,
	parameter int ROW       = 0
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire mvt_pkg::mat_wr_t                          wr,
	input  wire logic                                      prod_en,
	input  wire logic [mvt_pkg::DIM-1:0][mvt_pkg::DATA_W-1:0] vec,
	output mvt_pkg::lane_res_t                             res
);
	import mvt_pkg::*;

	localparam int PW = 2 * DATA_W - FRAC_BITS;
	localparam int SW = PW + 2;
	localparam logic [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;
	localparam logic signed [SW-1:0] SAT_HI = {{(SW-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
	localparam logic signed [SW-1:0] SAT_LO = {{(SW-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

	logic [DATA_W-1:0]        elem_q  [DIM];
	logic signed [PW-1:0]     prod_s1 [DIM];
	logic signed [SW-1:0]     sum;

	for (genvar j = 0; j < DIM; j++) begin : g_col
		logic signed [2*DATA_W-1:0] full;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				elem_q[j] <= (j == ROW) ? ONE : '0;
			end else if (wr.en && wr.row == 2'(ROW) && wr.col == 2'(j)) begin
				elem_q[j] <= wr.data;
			end
		end

		assign full = (2*DATA_W)'($signed(elem_q[j])) * (2*DATA_W)'($signed(vec[j]));

		// arithmetic shift: drop the fraction bits, floor rounding
		always_ff @(posedge clk) begin
			if (prod_en) begin
				prod_s1[j] <= $signed(full[2*DATA_W-1:FRAC_BITS]);
			end
		end
	end

	assign sum = SW'(prod_s1[0]) + SW'(prod_s1[1]) + SW'(prod_s1[2]) + SW'(prod_s1[3]);

	always_comb begin
		res.ovf = 1'b0;
		res.val = sum[DATA_W-1:0];
		if (sum > SAT_HI) begin
			res.val = SAT_HI[DATA_W-1:0];
			res.ovf = 1'b1;
		end else if (sum < SAT_LO) begin
			res.val = SAT_LO[DATA_W-1:0];
			res.ovf = 1'b1;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/mvt_merge.sv
// output register: gathers the four lane results and the overflow flag
`default_nettype none
module mvt_merge (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 valid_s1,
	input  wire mvt_pkg::lane_res_t [mvt_pkg::DIM-1:0] res,
	output logic                                      adv,
	mvt_rsp_if.source                                 rsp
);
	import mvt_pkg::*;

	logic valid_s2;

	// output slot is free or being emptied this cycle
	assign adv = !valid_s2 || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			rsp.out_x    <= $signed(res[0].val);
			rsp.out_y    <= $signed(res[1].val);
			rsp.out_z    <= $signed(res[2].val);
			rsp.out_w    <= $signed(res[3].val);
			rsp.overflow <= res[0].ovf | res[1].ovf | res[2].ovf | res[3].ovf;
		end
	end

	assign rsp.valid = valid_s2;

endmodule
`default_nettype wire

// File: hw/rtl/matrix_vector_transform_top.sv
// 4x4 matrix times vector transform in signed fixed point, top level
//
// req channel: func selects a matrix element load (row, col, value in in_x),
// a vec4 transform (x, y, z, w) or a point transform (w taken as 1.0).
// rsp channel: out_x..out_w, saturated to 32 bits, and overflow when any
// component sum clipped. Loads and the unused func code give no response.
// Four row lanes each hold one matrix row and multiply it by the vector;
// a merge register collects the rows.
// A response passes the product registers and then the merge register.
// Throughput: one request per cycle while rsp.ready holds, set by the four
// multipliers per lane working on every transfer.
// A load takes effect for the very next request.
// Reset loads the identity matrix and empties the pipeline.
// When the receiver stalls, the output register holds and the product stage
// still takes one more request; after that req.ready drops until rsp.ready.
`default_nettype none
module matrix_vector_transform_top #(
	parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	mvt_req_if.sink   req,
	mvt_rsp_if.source rsp
);
	import mvt_pkg::*;

	localparam logic [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;

	logic                           valid_s1;
	logic                           adv;
	logic                           take;
	logic                           is_xform;
	logic                           prod_en;
	mat_wr_t                        wr;
	logic [DIM-1:0][DATA_W-1:0]     vec;
	lane_res_t [DIM-1:0]            res;

	assign req.ready = !valid_s1 || adv;
	assign take      = req.valid && req.ready;

	always_comb begin
		is_xform = 1'b0;
		wr.en    = 1'b0;
		wr.row   = req.row;
		wr.col   = req.col;
		wr.data  = req.in_x;
		unique case (req.func) inside
			FUNC_LOAD:             wr.en    = take;
			FUNC_VEC, FUNC_POINT:  is_xform = 1'b1;
			default:               ;
		endcase
	end

	assign vec[0] = req.in_x;
	assign vec[1] = req.in_y;
	assign vec[2] = req.in_z;
	assign vec[3] = (req.func == FUNC_POINT) ? ONE : req.in_w;

	assign prod_en = take && is_xform;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= prod_en;
		end
	end

	for (genvar i = 0; i < DIM; i++) begin : g_lane
		mvt_lane #(
			.FRAC_BITS (FRAC_BITS),
			.ROW       (i)
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr      (wr),
			.prod_en (prod_en),
			.vec     (vec),
			.res     (res[i])
		);
	end

	mvt_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.res      (res),
		.adv      (adv),
		.rsp      (rsp)
	);

endmodule
`default_nettype wire

// File: sim/matrix_vector_transform_top_test.sv
// testbench for the matrix vector transform block with a self-checking scoreboard
`timescale 1ns / 100ps
module matrix_vector_transform_top_test;
	import mvt_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam longint SAT_MAX = 64'sd2147483647;
	localparam longint SAT_MIN = -64'sd2147483648;
	localparam func_t FUNC_UNUSED = 2'd3;
	localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC;

	typedef struct {
		logic signed [31:0] comp [4];
		logic               ovf;
	} vertex_t;

	class transform_scoreboard;
		logic signed [31:0] mat [16];
		vertex_t vertex_q [$];
		int errors;

		function new();
			for (int i = 0; i < 16; i++) begin
				mat[i] = ((i >> 2) == (i & 3)) ? ONE : '0;
			end
			errors = 0;
		endfunction

		// update the matrix copy or queue the transformed vertex
		function void note_request(func_t f, logic [1:0] row, logic [1:0] col,
			logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z, logic signed [31:0] w);
			longint vec [4];
			longint acc;
			longint prod;
			vertex_t v;
			if (f == FUNC_LOAD) begin
				mat[{row, col}] = x;
				return;
			end
			if (f != FUNC_VEC && f != FUNC_POINT)
				return;
			vec[0] = x;
			vec[1] = y;
			vec[2] = z;
			vec[3] = (f == FUNC_POINT) ? (longint'(1) << FRAC) : longint'(w);
			v.ovf = 1'b0;
			for (int i = 0; i < 4; i++) begin
				acc = 0;
				for (int j = 0; j < 4; j++) begin
					prod = longint'(mat[i*4+j]) * vec[j];
					acc += prod >>> FRAC;
				end
				if (acc > SAT_MAX) begin
					acc = SAT_MAX;
					v.ovf = 1'b1;
				end else if (acc < SAT_MIN) begin
					acc = SAT_MIN;
					v.ovf = 1'b1;
				end
				v.comp[i] = acc[31:0];
			end
			vertex_q.push_back(v);
		endfunction

		function void check_response(vertex_t got);
			vertex_t want;
			string names [4];
			names = '{"out_x", "out_y", "out_z", "out_w"};
			if (vertex_q.size() == 0) begin
				errors++;
				$display("%0t: response with nothing pending: x=%h y=%h z=%h w=%h ovf=%b",
					$time, got.comp[0], got.comp[1], got.comp[2], got.comp[3], got.ovf);
				return;
			end
			want = vertex_q.pop_front();
			for (int i = 0; i < 4; i++) begin
				if (got.comp[i] !== want.comp[i]) begin
					errors++;
					$display("%0t: %s mismatch: expected %h actual %h",
						$time, names[i], want.comp[i], got.comp[i]);
				end
			end
			if (got.ovf !== want.ovf) begin
				errors++;
				$display("%0t: overflow mismatch: expected %b actual %b",
					$time, want.ovf, got.ovf);
			end
		endfunction

		function int pending();
			return vertex_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	mvt_req_if req();
	mvt_rsp_if rsp();

	transform_scoreboard sb = new();
	int burst_left = 0;
	int n_items = 0;
	bit hold_req = 1'b0;

	matrix_vector_transform_top #(
		.FRAC_BITS(FRAC)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		int unsigned cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// random word, biased toward values that keep sums in range
	function automatic logic signed [31:0] rand_word();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return int'($urandom_range(0, 1 << 20)) - (1 << 19);
		if (r < 7)
			return $urandom;
		case ($urandom_range(0, 5))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return '0;
			3: return ONE;
			4: return -ONE;
			default: return -32'sd1;
		endcase
	endfunction

	// one request transfer, with sender bursts and gaps
	task automatic send_item(input func_t f, input logic [1:0] row, input logic [1:0] col,
		input logic signed [31:0] x, input logic signed [31:0] y,
		input logic signed [31:0] z, input logic signed [31:0] w);
		if (burst_left == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 20);
		end
		burst_left--;
		req.valid <= 1'b1;
		req.func <= f;
		req.row <= row;
		req.col <= col;
		req.in_x <= x;
		req.in_y <= y;
		req.in_z <= z;
		req.in_w <= w;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		sb.note_request(f, row, col, x, y, z, w);
		if (f != FUNC_UNUSED)
			n_items++;
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		// a load may still be in flight, let it settle
		repeat (4) @(posedge clk);
	endtask

	// receiver: stall pattern changes in spans, plus one long hold-off on request
	initial begin
		vertex_t got;
		int mode;
		int mode_left;
		int hold_left;
		mode = 0;
		mode_left = 0;
		hold_left = 0;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready) begin
				got.comp[0] = rsp.out_x;
				got.comp[1] = rsp.out_y;
				got.comp[2] = rsp.out_z;
				got.comp[3] = rsp.out_w;
				got.ovf = rsp.overflow;
				sb.check_response(got);
			end
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(16, 96);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else begin
				case (mode)
					0: rsp.ready <= 1'b1;
					1: rsp.ready <= ($urandom_range(0, 3) != 0);
					2: rsp.ready <= ($urandom_range(0, 3) == 0);
					default: rsp.ready <= ~rsp.ready;
				endcase
			end
		end
	end

	initial begin
		int r;
		int n;
		int base;
		int next_pause;
		bit hold_done;
		func_t f;
		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.func <= FUNC_LOAD;
		req.row <= '0;
		req.col <= '0;
		req.in_x <= '0;
		req.in_y <= '0;
		req.in_z <= '0;
		req.in_w <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity matrix passes extremes through unchanged
		send_item(FUNC_VEC, 2'd0, 2'd0, 32'sh7FFFFFFF, 32'sh80000000, '0, -32'sd1);
		send_item(FUNC_POINT, 2'd3, 2'd3, ONE, -(ONE * 5 / 2), 32'sd3, 32'sh7FFFFFFF);
		// unused func code leaves the matrix alone
		send_item(FUNC_UNUSED, 2'd3, 2'd3, 32'sh12345678, '1, '1, '1);
		send_item(FUNC_VEC, 2'd1, 2'd2, 32'sd12345, -32'sd7, ONE, 32'sh80000000);
		// saturate high, then low
		send_item(FUNC_LOAD, 2'd0, 2'd1, 32'sh7FFFFFFF, '1, '1, '1);
		send_item(FUNC_VEC, 2'd0, 2'd0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, '0, '0);
		send_item(FUNC_LOAD, 2'd0, 2'd0, 32'sh80000000, '0, '0, '0);
		send_item(FUNC_VEC, 2'd0, 2'd0, 32'sh7FFFFFFF, 32'sh80000000, '0, '0);
		send_item(FUNC_POINT, 2'd2, 2'd1, 32'sh80000000, 32'sh80000000, '1, '0);
		// tiny negative product rounds toward minus infinity
		send_item(FUNC_LOAD, 2'd2, 2'd3, -32'sd1, '0, '0, '0);
		send_item(FUNC_LOAD, 2'd3, 2'd3, '0, '0, '0, '0);
		send_item(FUNC_VEC, 2'd0, 2'd0, '0, '0, 32'sd1, 32'sd1);
		send_item(FUNC_POINT, 2'd0, 2'd0, 32'sd3, -32'sd3, -32'sd1, 32'sd99);
		// back to identity
		send_item(FUNC_LOAD, 2'd0, 2'd0, ONE, '0, '0, '0);
		send_item(FUNC_LOAD, 2'd0, 2'd1, '0, '0, '0, '0);
		send_item(FUNC_LOAD, 2'd2, 2'd3, '0, '0, '0, '0);
		send_item(FUNC_LOAD, 2'd3, 2'd3, ONE, '0, '0, '0);
		send_item(FUNC_VEC, 2'd1, 2'd1, 32'sh00010000, 32'sh7FFF0000, 32'sh80010000, ONE);
		drain();

		n_items = 0;
		next_pause = 500;
		hold_done = 1'b0;
		while (n_items < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 12) begin
				// whole matrix, starting at a random element
				base = $urandom_range(0, 15);
				for (int i = 0; i < 16; i++) begin
					n = (base + i) & 15;
					send_item(FUNC_LOAD, n[3:2], n[1:0], rand_word(), $urandom, $urandom,
						$urandom);
				end
			end else if (r < 24) begin
				repeat ($urandom_range(1, 3))
					send_item(FUNC_LOAD, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
						rand_word(), $urandom, $urandom, $urandom);
			end else if (r < 27) begin
				send_item(FUNC_UNUSED, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
					$urandom, $urandom, $urandom, $urandom);
			end else begin
				repeat ($urandom_range(1, 12)) begin
					f = ($urandom_range(0, 2) == 0) ? FUNC_POINT : FUNC_VEC;
					send_item(f, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
						rand_word(), rand_word(), rand_word(), rand_word());
				end
			end
			if (!hold_done && n_items >= 700) begin
				hold_done = 1'b1;
				hold_req = 1'b1;
			end
			if (n_items >= next_pause) begin
				next_pause += 500;
				drain();
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
